// ===== design/prf_pkg.sv =====
`timescale 1ns / 1ps

package prf_pkg;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 13;
  localparam int PB_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int EPOCH_W    = 4;

  // Default sizes of the row store and the pixel windows.
  localparam int DEF_MAX_ROW_BYTES   = 4096;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd2;

  // Filter type codes.
  localparam logic [BYTE_W-1:0] FT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FT_PAETH = 8'd4;

  // Row store control and status.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic flush;
  } rs_ctrl_t;

  typedef struct packed {
    logic clearing;
    logic wrap;
  } rs_stat_t;

  // Remainder unit status.
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  // One result item in the output queue.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_item_t;

  // Rebuild one data byte from its filtered value and its neighbors.
  function automatic logic [BYTE_W-1:0] predict(
    input logic [BYTE_W-1:0] ftype,
    input logic [BYTE_W-1:0] x,
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    logic signed [10:0] sa, sb, sc, p, pa, pb, pc;
    logic [BYTE_W:0]    avg_sum;
    logic [BYTE_W-1:0]  pr;
    logic [BYTE_W-1:0]  res;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    p  = sa + sb - sc;
    pa = (p >= sa) ? p - sa : sa - p;
    pb = (p >= sb) ? p - sb : sb - p;
    pc = (p >= sc) ? p - sc : sc - p;
    if (pa <= pb && pa <= pc) begin
      pr = a;
    end else if (pb <= pc) begin
      pr = b;
    end else begin
      pr = c;
    end
    avg_sum = {1'b0, a} + {1'b0, b};
    case (ftype)
      FT_SUB:   res = x + a;
      FT_UP:    res = x + b;
      FT_AVG:   res = x + avg_sum[BYTE_W:1];
      FT_PAETH: res = x + pr;
      default:  res = x;
    endcase
    return res;
  endfunction

endpackage

// ===== design/prf_ifs.sv =====
`timescale 1ns / 1ps

// Input byte channel.
interface prf_in_if;
  logic                          valid;
  logic                          ready;
  logic [prf_pkg::BYTE_W-1:0]    in_byte;
  logic                          flush;
  modport source (output valid, output in_byte, output flush, input ready);
  modport sink (input valid, input in_byte, input flush, output ready);
endinterface

// Result byte channel.
interface prf_out_if;
  logic                          valid;
  logic                          ready;
  logic [prf_pkg::BYTE_W-1:0]    out_byte;
  logic                          last_of_item;
  modport source (output valid, output out_byte, output last_of_item, input ready);
  modport sink (input valid, input out_byte, input last_of_item, output ready);
endinterface

// Configuration write channel.
interface prf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [prf_pkg::CFG_IDX_W-1:0]    index;
  logic [prf_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/prf_mod.sv =====
`timescale 1ns / 1ps

// Iterative remainder unit: one dividend bit per cycle.
module prf_mod #(
  parameter int DW = 12,
  parameter int SW = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [prf_pkg::PB_W-1:0]    divisor_i,
  output prf_pkg::mod_stat_t          stat_o,
  output logic [SW-1:0]               rem_o
);

  localparam int PBW = prf_pkg::PB_W;
  localparam int CW  = $clog2(DW + 1);

  logic            busy_q;
  logic [CW-1:0]   cnt_q;
  logic [DW-1:0]   shift_q;
  logic [PBW-1:0]  div_q;
  logic [PBW-1:0]  rem_q;
  logic [PBW:0]    trial;
  logic [PBW-1:0]  rem_d;
  logic            last_step;

  // Restoring step: shift in one bit, subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, shift_q[DW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = PBW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[PBW-1:0];
    end
    last_step = busy_q && (cnt_q == CW'(DW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      div_q   <= divisor_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= shift_q << 1;
      rem_q   <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last_step;
  assign rem_o       = SW'(rem_d);

endmodule

// ===== design/prf_row_store.sv =====
`timescale 1ns / 1ps

// Previous-row byte store. Each entry carries the epoch in which it was
// written; an entry from an older epoch reads as zero, so a flush clears the
// row by advancing the epoch. When the epoch wraps, a sweep rewrites every entry.
module prf_row_store #(
  parameter int Depth = prf_pkg::DEF_MAX_ROW_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prf_pkg::rs_ctrl_t             ctrl_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [prf_pkg::BYTE_W-1:0]    wr_data_i,
  output logic [prf_pkg::BYTE_W-1:0]    rd_data_o,
  output prf_pkg::rs_stat_t             stat_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int BW = prf_pkg::BYTE_W;
  localparam int EW = prf_pkg::EPOCH_W;
  localparam int WW = BW + EW;

  logic [WW-1:0]  mem_q [Depth];
  logic [WW-1:0]  rd_word_q;
  logic           byp_q;
  logic [BW-1:0]  byp_data_q;
  logic           clr_q;
  logic [AW-1:0]  clr_ptr_q;
  logic [EW-1:0]  epoch_q;

  // Memory array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_ptr_q] <= '0;
    end else if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= {epoch_q, wr_data_i};
    end
    if (ctrl_i.rd_en) begin
      rd_word_q  <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // Epoch, clearing sweep and write-to-read forwarding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q     <= 1'b0;
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
      epoch_q   <= '0;
    end else begin
      if (ctrl_i.rd_en) begin
        byp_q <= ctrl_i.wr_en && (wr_addr_i == rd_addr_i);
      end
      if (clr_q) begin
        if (clr_ptr_q == AW'(Depth - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_ptr_q <= clr_ptr_q + AW'(1);
        end
      end
      if (ctrl_i.flush) begin
        if (&epoch_q) begin
          epoch_q   <= '0;
          clr_q     <= 1'b1;
          clr_ptr_q <= '0;
        end else begin
          epoch_q <= epoch_q + EW'(1);
        end
      end
    end
  end

  // An entry of an older epoch reads as zero.
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_word_q[WW-1 -: EW] == epoch_q) begin
      rd_data_o = rd_word_q[BW-1:0];
    end else begin
      rd_data_o = '0;
    end
  end

  assign stat_o.clearing = clr_q;
  assign stat_o.wrap     = &epoch_q;

endmodule

// ===== design/png_row_filter_codec.sv =====
`timescale 1ns / 1ps

// PNG scanline filter codec, one stream byte per item.
// Channels: in_i carries in_byte and flush, out_o carries out_byte and
// last_of_item, cfg_i writes mode (0), pixel_bytes (1) and row_bytes (2).
// cfg_i is always ready; write it only while the block is idle.
// In decode mode the first byte of a row is its filter type and gives no
// result; in encode mode the first byte of a row gives two results, the Up
// filter code and then the difference.
// Path: an accepted item is registered in stage two and its result in the
// output queue before it is offered; the second result of an encoded row start follows the first.
// Throughput: one item per cycle while out_o takes results, set by the
// single read port of the row store; an encoded row start holds the next
// item until both of its results are queued. After each configuration write
// the input stalls while the remainder unit recomputes the pixel slot.
// Reset: the row store is swept to zero before the first item is taken;
// the same sweep follows every sixteenth flush.
// Stalls: a two-entry output queue sits behind the core; when out_o stalls
// the queue fills and in_i ready drops while stage two holds a result.
module png_row_filter_codec #(
  parameter int MAX_ROW_BYTES   = prf_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = prf_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  prf_in_if.sink        in_i,
  prf_out_if.source     out_o,
  prf_cfg_if.sink       cfg_i
);

  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int SW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PW  = prf_pkg::POS_W;
  localparam int BW  = prf_pkg::BYTE_W;
  localparam int PBW = prf_pkg::PB_W;

  // Configuration and row position state.
  logic             mode_q;
  logic [PBW-1:0]   pb_q;
  logic [PW-1:0]    rb_q;
  logic             cfg_pend_q;
  logic [PW-1:0]    pos_q;
  logic [BW-1:0]    ftype_q;
  logic [SW-1:0]    slot_q;

  // Input side decode.
  logic [PBW-1:0]   pb_cl;
  logic [PW-1:0]    rb_cl;
  logic [PW:0]      row_end;
  logic             is_filt;
  logic [PW-1:0]    idx_raw;
  logic [AW-1:0]    idx_cl;
  logic             has_left;
  logic [PW:0]      pos_inc;
  logic             row_done;
  logic [SW:0]      slot_inc;
  logic             slot_wrap;
  logic             in_fire;
  logic             data_fire;
  logic             cfg_fire;

  // Second stage.
  logic             s1_valid_q;
  logic             s1_flush_q;
  logic             s1_filt_q;
  logic             s1_hdr_q;
  logic             s1_rowstart_q;
  logic [BW-1:0]    s1_byte_q;
  logic             s1_enc_q;
  logic [BW-1:0]    s1_ftype_q;
  logic [AW-1:0]    s1_idx_q;
  logic [SW-1:0]    s1_slot_q;
  logic             s1_left_ok_q;
  logic             s1_out;
  logic             s1_fire;
  logic             push;
  logic [BW-1:0]    up;
  logic [BW-1:0]    left;
  logic [BW-1:0]    upleft;
  logic [BW-1:0]    dec_res;
  logic [BW-1:0]    res;
  logic [BW-1:0]    wdata;
  prf_pkg::out_item_t push_item;

  // Pixel windows.
  logic [BW-1:0]    left_q   [MAX_PIXEL_BYTES];
  logic [BW-1:0]    upleft_q [MAX_PIXEL_BYTES];

  // Output queue.
  prf_pkg::out_item_t fifo_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  // Submodule links.
  prf_pkg::rs_ctrl_t  rs_ctrl;
  prf_pkg::rs_stat_t  rs_stat;
  prf_pkg::mod_stat_t mod_stat;
  logic [BW-1:0]      rs_rdata;
  logic [SW-1:0]      mod_rem;
  logic [AW-1:0]      mod_dividend;

  // Clamp the registers and locate the next byte in its row.
  always_comb begin
    pb_cl = pb_q;
    if (pb_q == '0) begin
      pb_cl = PBW'(1);
    end else if (32'(pb_q) > 32'(MAX_PIXEL_BYTES)) begin
      pb_cl = PBW'(MAX_PIXEL_BYTES);
    end
    rb_cl = rb_q;
    if (rb_q == '0) begin
      rb_cl = PW'(1);
    end else if (32'(rb_q) > 32'(MAX_ROW_BYTES)) begin
      rb_cl = PW'(MAX_ROW_BYTES);
    end
    row_end = mode_q ? {1'b0, rb_cl} : {1'b0, rb_cl} + (PW + 1)'(1);
    is_filt = !mode_q && (pos_q == '0);
    idx_raw = mode_q ? pos_q : pos_q - PW'(1);
    if (32'(idx_raw) >= 32'(MAX_ROW_BYTES)) begin
      idx_cl = AW'(MAX_ROW_BYTES - 1);
    end else begin
      idx_cl = AW'(idx_raw);
    end
    has_left  = 32'(idx_cl) >= 32'(pb_cl);
    pos_inc   = {1'b0, pos_q} + (PW + 1)'(1);
    row_done  = pos_inc >= row_end;
    slot_inc  = {1'b0, slot_q} + (SW + 1)'(1);
    slot_wrap = 32'(slot_inc) == 32'(pb_cl);
  end

  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire   = in_i.valid && in_i.ready;
  assign data_fire = in_fire && !in_i.flush && !is_filt;

  assign in_i.ready = !cfg_pend_q && !mod_stat.busy && !rs_stat.clearing
                      && !(s1_valid_q && s1_flush_q && rs_stat.wrap)
                      && (!s1_valid_q || s1_fire);

  // Registers, row position, filter type and pixel slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      pb_q       <= PBW'(1);
      rb_q       <= PW'(1);
      cfg_pend_q <= 1'b0;
      pos_q      <= '0;
      ftype_q    <= '0;
      slot_q     <= '0;
    end else begin
      cfg_pend_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          prf_pkg::CFG_MODE:        mode_q <= cfg_i.data[0];
          prf_pkg::CFG_PIXEL_BYTES: pb_q   <= cfg_i.data[PBW-1:0];
          prf_pkg::CFG_ROW_BYTES:   rb_q   <= cfg_i.data;
          default: ;
        endcase
      end
      if (mod_stat.done) begin
        slot_q <= mod_rem;
      end
      if (in_fire) begin
        if (in_i.flush) begin
          pos_q   <= '0;
          ftype_q <= '0;
          slot_q  <= '0;
        end else if (is_filt) begin
          ftype_q <= in_i.in_byte;
          pos_q   <= PW'(1);
          slot_q  <= '0;
        end else begin
          pos_q  <= row_done ? '0 : pos_inc[PW-1:0];
          slot_q <= (row_done || slot_wrap) ? '0 : slot_inc[SW-1:0];
        end
      end
    end
  end

  // Recompute the pixel slot after a configuration write.
  assign mod_dividend = is_filt ? '0 : idx_cl;

  prf_mod #(
    .DW (AW),
    .SW (SW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_pend_q),
    .dividend_i (mod_dividend),
    .divisor_i  (pb_cl),
    .stat_o     (mod_stat),
    .rem_o      (mod_rem)
  );

  // Row store: read at acceptance, write back when the item leaves stage two.
  assign rs_ctrl.rd_en = data_fire;
  assign rs_ctrl.wr_en = s1_fire && s1_out;
  assign rs_ctrl.flush = s1_fire && s1_flush_q;

  prf_row_store #(
    .Depth (MAX_ROW_BYTES)
  ) u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rs_ctrl),
    .rd_addr_i (idx_cl),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (wdata),
    .rd_data_o (rs_rdata),
    .stat_o    (rs_stat)
  );

  // Stage two control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s1_flush_q    <= 1'b0;
      s1_filt_q     <= 1'b0;
      s1_hdr_q      <= 1'b0;
      s1_rowstart_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q    <= 1'b1;
      s1_flush_q    <= in_i.flush;
      s1_filt_q     <= is_filt;
      s1_hdr_q      <= mode_q && (pos_q == '0) && !in_i.flush;
      s1_rowstart_q <= pos_q == '0;
    end else begin
      if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (push && s1_hdr_q) begin
        s1_hdr_q <= 1'b0;
      end
    end
  end

  // Stage two payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q    <= in_i.in_byte;
      s1_enc_q     <= mode_q;
      s1_ftype_q   <= ftype_q;
      s1_idx_q     <= idx_cl;
      s1_slot_q    <= slot_q;
      s1_left_ok_q <= has_left;
    end
  end

  // Predict, rebuild or difference the byte.
  always_comb begin
    up      = rs_rdata;
    left    = s1_left_ok_q ? left_q[s1_slot_q] : '0;
    upleft  = s1_left_ok_q ? upleft_q[s1_slot_q] : '0;
    dec_res = prf_pkg::predict(s1_ftype_q, s1_byte_q, left, up, upleft);
    res     = s1_enc_q ? s1_byte_q - up : dec_res;
    wdata   = s1_enc_q ? s1_byte_q : dec_res;
    s1_out  = s1_valid_q && !s1_flush_q && !s1_filt_q;
    push    = s1_out && (cnt_q != 2'd2);
    s1_fire = s1_valid_q && (!s1_out || (push && !s1_hdr_q));
    if (s1_hdr_q) begin
      push_item.data = prf_pkg::FT_UP;
      push_item.last = 1'b0;
    end else begin
      push_item.data = res;
      push_item.last = 1'b1;
    end
  end

  // Pixel windows, zeroed at row start and at flush.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i]   <= '0;
        upleft_q[i] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_flush_q || s1_rowstart_q) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_q[i]   <= '0;
          upleft_q[i] <= '0;
        end
      end
      if (s1_out) begin
        left_q[s1_slot_q]   <= wdata;
        upleft_q[s1_slot_q] <= up;
      end
    end
  end

  // Two-entry output queue.
  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign out_o.valid        = cnt_q != '0;
  assign out_o.out_byte     = fifo_q[rd_ptr_q].data;
  assign out_o.last_of_item = fifo_q[rd_ptr_q].last;

endmodule

// ===== design/prf_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the codec.
module prf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_flush,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prf_pkg::BYTE_W-1:0]    out_byte,
  input logic                          out_last
);

  logic        in_fire;
  logic        out_fire;
  logic        hdr_seen_q;
  logic [31:0] pend_q;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Track a delivered row-start code; count non-flush items less final results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_seen_q <= 1'b0;
      pend_q     <= '0;
    end else begin
      if (out_fire) begin
        hdr_seen_q <= !out_last;
      end
      if ((in_fire && !in_flush) && !(out_fire && out_last)) begin
        pend_q <= pend_q + 32'd1;
      end else if (!(in_fire && !in_flush) && (out_fire && out_last)) begin
        pend_q <= pend_q - 32'd1;
      end
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // The only result that is not last is the Up filter code.
  a_hdr_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> out_byte == prf_pkg::FT_UP)
    else $error("non-final result is not the Up filter code");

  // A row-start code is followed by the final result of the same item.
  a_hdr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && hdr_seen_q |-> out_last)
    else $error("row-start code not followed by its data result");

  // No final result without an accepted item behind it.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_last |-> pend_q != 32'd0)
    else $error("final result without a pending item");

endmodule

bind png_row_filter_codec prf_checker u_prf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_flush  (in_i.flush),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .out_last  (out_o.last_of_item)
);
